// ===== design/sccb_register_master_macros.svh =====
// assertion macros for the sccb register master
`ifndef SCCB_REGISTER_MASTER_MACROS_SVH
`define SCCB_REGISTER_MASTER_MACROS_SVH

`ifndef ASSERT_OFF

`define SCCBM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sccbm assertion failed");

`define SCCBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sccbm assertion failed");

`else

`define SCCBM_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define SCCBM_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/sccbm_pkg.sv =====
package sccbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START1   = 4'd1,
    PH_DEVW     = 4'd2,
    PH_ACKDEVW  = 4'd3,
    PH_REG      = 4'd4,
    PH_ACKREG   = 4'd5,
    PH_DATA     = 4'd6,
    PH_ACKDATA  = 4'd7,
    PH_STOPMID  = 4'd8,
    PH_START2   = 4'd9,
    PH_DEVR     = 4'd10,
    PH_ACKDEVR  = 4'd11,
    PH_RECV     = 4'd12,
    PH_NOACK    = 4'd13,
    PH_STOPEND  = 4'd14,
    PH_STOPFAIL = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_START = 3'd1,
    K_SEND  = 3'd2,
    K_ACK   = 3'd3,
    K_STOP  = 3'd4,
    K_RECV  = 3'd5,
    K_NOACK = 3'd6
  } step_kind_t;

  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_DELAY    = 1'b1;

  localparam logic [7:0]  DEV_ADDR_RESET = 8'd66;
  localparam logic [15:0] DELAY_RESET    = 16'd400;

  // bit 1 scl, bit 0 sda
  localparam logic [1:0] LINES_RELEASED = 2'b11;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  step;
    logic [3:0]  bit_count;
    logic [7:0]  shift;
    logic [15:0] tick;
    logic        is_read;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [7:0]  received;
    logic [1:0]  lines;
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       success;
    logic [7:0] read_byte;
  } res_t;

  function automatic step_kind_t kind_of(phase_t p);
    step_kind_t k;
    unique case (p)
      PH_START1, PH_START2:                    k = K_START;
      PH_DEVW, PH_REG, PH_DATA, PH_DEVR:       k = K_SEND;
      PH_ACKDEVW, PH_ACKREG, PH_ACKDATA,
      PH_ACKDEVR:                              k = K_ACK;
      PH_STOPMID, PH_STOPEND, PH_STOPFAIL:     k = K_STOP;
      PH_RECV:                                 k = K_RECV;
      PH_NOACK:                                k = K_NOACK;
      default:                                 k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] steps_of(step_kind_t k);
    logic [2:0] n;
    unique case (k)
      K_STOP, K_NOACK: n = 3'd4;
      K_RECV:          n = 3'd2;
      K_NONE:          n = 3'd1;
      default:         n = 3'd3;
    endcase
    return n;
  endfunction

  // line levels on entry to step s of a bus step of kind k
  function automatic logic [1:0] apply_lines(step_kind_t k, logic [1:0] s, logic msb,
                                             logic [1:0] lv);
    logic [1:0] r;
    r = lv;
    unique case (k)
      K_START: begin
        if (s == 2'd0) r = 2'b11;
        else           r[0] = 1'b0;
      end
      K_SEND: begin
        if (s == 2'd0)      r[1] = 1'b0;
        else if (s == 2'd1) r[0] = msb;
        else                r[1] = 1'b1;
      end
      K_ACK: begin
        if (s == 2'd0)      r[1] = 1'b0;
        else if (s == 2'd1) r[0] = 1'b1;
        else                r[1] = 1'b1;
      end
      K_STOP: begin
        if (s == 2'd0)      r[1] = 1'b0;
        else if (s == 2'd1) r[0] = 1'b0;
        else if (s == 2'd2) r[1] = 1'b1;
        else                r[0] = 1'b1;
      end
      K_RECV: begin
        if (s == 2'd0) r = 2'b01;
        else           r[1] = 1'b1;
      end
      K_NOACK: begin
        if (s == 2'd0 || s == 2'd3) r[1] = 1'b0;
        else if (s == 2'd1)         r[0] = 1'b1;
        else                        r[1] = 1'b1;
      end
      default: r = lv;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sccbm_step.sv =====
module sccbm_step (
  input  sccbm_pkg::state_t cur,
  input  logic [1:0]        kind,
  input  logic [7:0]        reg_addr,
  input  logic [7:0]        wr_data,
  input  logic              sda_in,
  input  logic [7:0]        dev_addr,
  input  logic [15:0]       delay,
  output sccbm_pkg::state_t nxt,
  output sccbm_pkg::res_t   res
);
  import sccbm_pkg::*;

  state_t     s0;
  step_kind_t k;
  logic [15:0] delay_eff;
  logic       active;
  logic       expire;
  logic       last_step;
  logic [3:0] bit_next;
  logic       more_bits;
  phase_t     en_phase;
  logic [7:0] en_byte;
  logic       go_enter;

  // request tick: latch the request and enter the first start
  always_comb begin
    s0 = cur;
    if (cur.phase == PH_IDLE && (kind == REQ_WRITE || kind == REQ_READ)) begin
      s0.is_read   = (kind == REQ_READ);
      s0.addr      = reg_addr;
      s0.data      = wr_data;
      s0.tick      = '0;
      s0.phase     = PH_START1;
      s0.step      = '0;
      s0.bit_count = '0;
      s0.shift     = '0;
      s0.lines     = apply_lines(K_START, 2'd0, 1'b0, cur.lines);
    end
  end

  assign delay_eff = (delay == 16'd0) ? 16'd1 : delay;
  assign active    = (s0.phase != PH_IDLE);
  assign expire    = ({1'b0, s0.tick} + 17'd1) >= {1'b0, delay_eff};
  assign k         = kind_of(s0.phase);
  assign last_step = ({1'b0, s0.step} + 3'd1) >= steps_of(k);
  assign bit_next  = s0.bit_count + 4'd1;
  assign more_bits = (k == K_SEND || k == K_RECV) && (bit_next < 4'd8);

  // next state
  always_comb begin
    nxt      = s0;
    en_phase = PH_IDLE;
    en_byte  = '0;
    go_enter = 1'b0;
    if (active) begin
      if (!expire) begin
        nxt.tick = s0.tick + 16'd1;
      end else begin
        nxt.tick = '0;
        if (k == K_RECV && s0.step == 2'd1) nxt.shift = {s0.shift[6:0], sda_in};
        if (!last_step) begin
          nxt.step  = s0.step + 2'd1;
          nxt.lines = apply_lines(k, nxt.step, nxt.shift[7], s0.lines);
        end else begin
          if (k == K_SEND) nxt.shift = {s0.shift[6:0], 1'b0};
          if (k == K_SEND || k == K_RECV) nxt.bit_count = bit_next;
          if (more_bits) begin
            nxt.step  = '0;
            nxt.lines = apply_lines(k, 2'd0, nxt.shift[7], s0.lines);
          end else begin
            unique case (s0.phase)
              PH_START1: begin
                en_phase = PH_DEVW;
                en_byte  = dev_addr;
                go_enter = 1'b1;
              end
              PH_DEVW: begin
                en_phase = PH_ACKDEVW;
                go_enter = 1'b1;
              end
              PH_ACKDEVW: begin
                en_phase = sda_in ? PH_STOPFAIL : PH_REG;
                en_byte  = sda_in ? 8'd0 : s0.addr;
                go_enter = 1'b1;
              end
              PH_REG: begin
                en_phase = PH_ACKREG;
                go_enter = 1'b1;
              end
              PH_ACKREG: begin
                en_phase = s0.is_read ? PH_STOPMID : PH_DATA;
                en_byte  = s0.is_read ? 8'd0 : s0.data;
                go_enter = 1'b1;
              end
              PH_DATA: begin
                en_phase = PH_ACKDATA;
                go_enter = 1'b1;
              end
              PH_ACKDATA: begin
                en_phase = PH_STOPEND;
                go_enter = 1'b1;
              end
              PH_STOPMID: begin
                en_phase = PH_START2;
                go_enter = 1'b1;
              end
              PH_START2: begin
                en_phase = PH_DEVR;
                en_byte  = dev_addr + 8'd1;
                go_enter = 1'b1;
              end
              PH_DEVR: begin
                en_phase = PH_ACKDEVR;
                go_enter = 1'b1;
              end
              PH_ACKDEVR: begin
                en_phase = sda_in ? PH_STOPFAIL : PH_RECV;
                go_enter = 1'b1;
              end
              PH_RECV: begin
                nxt.received = nxt.shift;
                en_phase     = PH_NOACK;
                go_enter     = 1'b1;
              end
              PH_NOACK: begin
                en_phase = PH_STOPEND;
                go_enter = 1'b1;
              end
              default: begin
                nxt.phase     = PH_IDLE;
                nxt.step      = '0;
                nxt.bit_count = '0;
              end
            endcase
            if (go_enter) begin
              nxt.phase     = en_phase;
              nxt.step      = '0;
              nxt.bit_count = '0;
              nxt.shift     = en_byte;
              nxt.lines     = apply_lines(kind_of(en_phase), 2'd0, en_byte[7], s0.lines);
            end
          end
        end
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl       = s0.lines[1];
    res.sda       = s0.lines[0];
    res.done      = active && expire && last_step &&
                    (s0.phase == PH_STOPEND || s0.phase == PH_STOPFAIL);
    res.success   = res.done && (s0.phase == PH_STOPEND);
    res.busy      = active && !res.done;
    res.read_byte = nxt.received;
  end

endmodule

// ===== design/sccb_register_master.sv =====
// channel   direction  handshake            payload
// in        receive    in_valid / in_stall  kind, reg_addr, wr_data, sda_in
// out       send       out_valid / out_stall scl_out, sda_out, busy_res, done_res,
//                                           success, read_byte
// cfg       receive    cfg_wr_en            cfg_index, cfg_wdata
//
// one beat in gives one beat out, in the next cycle, through the result register
// a new beat is taken every cycle while the result register is empty or being taken
// the whole tick update is one pass of logic from the state register to itself
// out_stall, while out_valid is high, holds the result register and stalls the input side in the same cycle
// synchronous reset: lines released, bus idle, address 66, 400 ticks per bus step
`include "sccb_register_master_macros.svh"

module sccb_register_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wr_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic        success,
  output logic [7:0]  read_byte,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import sccbm_pkg::*;

  state_t      state;
  state_t      state_next;
  res_t        res;
  logic [7:0]  dev_addr;
  logic [15:0] delay;
  logic        in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  sccbm_step u_step (
    .cur      (state),
    .kind     (kind),
    .reg_addr (reg_addr),
    .wr_data  (wr_data),
    .sda_in   (sda_in),
    .dev_addr (dev_addr),
    .delay    (delay),
    .nxt      (state_next),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RESET;
      delay    <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEV_ADDR: dev_addr <= cfg_wdata[7:0];
        CFG_DELAY:    delay    <= cfg_wdata;
        default:      delay    <= delay;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, step: '0, bit_count: '0, shift: '0, tick: '0,
                 is_read: 1'b0, addr: '0, data: '0, received: '0,
                 lines: LINES_RELEASED};
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      scl_out   <= res.scl;
      sda_out   <= res.sda;
      busy_res  <= res.busy;
      done_res  <= res.done;
      success   <= res.success;
      read_byte <= res.read_byte;
    end
  end

  `SCCBM_ASSERT_SAME(a_done_not_busy, clk, rst, out_valid && done_res, !busy_res)
  `SCCBM_ASSERT_SAME(a_success_with_done, clk, rst, out_valid && success, done_res)
  `SCCBM_ASSERT_NEXT(a_done_goes_idle, clk, rst, in_accept && res.done, state.phase == PH_IDLE)
  `SCCBM_ASSERT_SAME(a_idle_clean, clk, rst, state.phase == PH_IDLE,
                     state.step == 2'd0 && state.bit_count == 4'd0)

endmodule

// ===== test/sccb_register_master_test.sv =====
module sccb_register_master_test;
  import sccbm_pkg::*;

  localparam logic [1:0] TICK_PLAIN = 2'd0;
  localparam logic [1:0] TICK_ODD   = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic [1:0] {ACK_ALL, NACK_DEVW, NACK_DEVR, ACK_NOISE} reply_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [15:0] dly;
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [7:0]  data;
    reply_t      reply;
    logic [7:0]  rx;
    logic        typed;
    res_t        want;
  } script_row_t;

  localparam res_t IDLE_AT_RESET =
    '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0, success: 1'b0, read_byte: 8'h00};
  localparam res_t START_AT_RESET =
    '{scl: 1'b1, sda: 1'b1, busy: 1'b1, done: 1'b0, success: 1'b0, read_byte: 8'h00};

  script_row_t script [10] = '{
    '{8'd66,  16'd400,   TICK_PLAIN, 8'h00, 8'h00, ACK_ALL,   8'h00, 1'b1, IDLE_AT_RESET},
    '{8'd66,  16'd400,   TICK_ODD,   8'hFF, 8'hFF, ACK_ALL,   8'h00, 1'b1, IDLE_AT_RESET},
    '{8'd66,  16'd1,     REQ_WRITE,  8'h00, 8'h00, NACK_DEVW, 8'h00, 1'b1, START_AT_RESET},
    '{8'd0,   16'd1,     REQ_WRITE,  8'hFF, 8'hFF, ACK_ALL,   8'h00, 1'b0, '0},
    '{8'd255, 16'd0,     REQ_READ,   8'h3C, 8'h00, ACK_ALL,   8'hA5, 1'b0, '0},
    '{8'd254, 16'd1,     REQ_READ,   8'h56, 8'h00, NACK_DEVW, 8'h00, 1'b0, '0},
    '{8'd254, 16'd1,     REQ_READ,   8'h78, 8'h00, NACK_DEVR, 8'hAA, 1'b0, '0},
    '{8'd129, 16'd2,     REQ_WRITE,  8'h00, 8'hFF, ACK_NOISE, 8'h00, 1'b0, '0},
    '{8'd129, 16'd65535, TICK_PLAIN, 8'h55, 8'hAA, ACK_ALL,   8'h00, 1'b0, '0},
    '{8'd129, 16'd65535, TICK_ODD,   8'hAA, 8'h55, ACK_ALL,   8'h00, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = TICK_PLAIN;
  logic [7:0]  reg_addr = 8'h00;
  logic [7:0]  wr_data = 8'h00;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic        success;
  logic [7:0]  read_byte;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_DEV_ADDR;
  logic [15:0] cfg_wdata = 16'h0000;

  // predicted bus master state
  phase_t      m_ph = PH_IDLE;
  int          m_step = 0;
  int          m_bits = 0;
  int          m_ticks = 0;
  logic [7:0]  m_shift = 8'h00;
  logic [7:0]  m_addr = 8'h00;
  logic [7:0]  m_data = 8'h00;
  logic [7:0]  m_rx = 8'h00;
  logic        m_rd = 1'b0;
  logic [1:0]  m_lines = LINES_RELEASED;
  logic [7:0]  m_dev = DEV_ADDR_RESET;
  logic [15:0] m_delay = DELAY_RESET;

  res_t        tick_out_q [$];
  res_t        head;
  int          items_fed = 0;
  int          beats_seen = 0;
  int          bad_count = 0;
  int          burst_left = 0;
  int          gap_max = 3;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          cycle_count = 0;

  sccb_register_master dut (.*);

  always #1 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic step_kind_t step_class(phase_t p);
    step_kind_t k;
    case (p)
      PH_START1, PH_START2:                          k = K_START;
      PH_DEVW, PH_REG, PH_DATA, PH_DEVR:             k = K_SEND;
      PH_ACKDEVW, PH_ACKREG, PH_ACKDATA, PH_ACKDEVR: k = K_ACK;
      PH_STOPMID, PH_STOPEND, PH_STOPFAIL:           k = K_STOP;
      PH_RECV:                                       k = K_RECV;
      PH_NOACK:                                      k = K_NOACK;
      default:                                       k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic int steps_in(step_kind_t k);
    int n;
    case (k)
      K_STOP, K_NOACK: n = 4;
      K_RECV:          n = 2;
      K_NONE:          n = 1;
      default:         n = 3;
    endcase
    return n;
  endfunction

  // bit 1 scl, bit 0 sda, as set on entry to the current step
  function automatic void set_levels();
    case (step_class(m_ph))
      K_START: begin
        if (m_step == 0) m_lines = 2'b11;
        else m_lines[0] = 1'b0;
      end
      K_SEND: begin
        if (m_step == 0) m_lines[1] = 1'b0;
        else if (m_step == 1) m_lines[0] = m_shift[7];
        else m_lines[1] = 1'b1;
      end
      K_ACK: begin
        if (m_step == 0) m_lines[1] = 1'b0;
        else if (m_step == 1) m_lines[0] = 1'b1;
        else m_lines[1] = 1'b1;
      end
      K_STOP: begin
        if (m_step == 0) m_lines[1] = 1'b0;
        else if (m_step == 1) m_lines[0] = 1'b0;
        else if (m_step == 2) m_lines[1] = 1'b1;
        else m_lines[0] = 1'b1;
      end
      K_RECV: begin
        if (m_step == 0) m_lines = 2'b01;
        else m_lines[1] = 1'b1;
      end
      K_NOACK: begin
        if (m_step == 0 || m_step == 3) m_lines[1] = 1'b0;
        else if (m_step == 1) m_lines[0] = 1'b1;
        else m_lines[1] = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void enter_phase(phase_t p, logic [7:0] b);
    m_ph = p;
    m_step = 0;
    m_bits = 0;
    m_shift = b;
    set_levels();
  endfunction

  // end of a bus step: 0 carry on, 1 finished well, 2 finished failed
  function automatic int close_step(logic sda);
    step_kind_t k;
    int result;
    k = step_class(m_ph);
    if (k == K_RECV && m_step == 1) m_shift = {m_shift[6:0], sda};
    if (m_step + 1 < steps_in(k)) begin
      m_step++;
      set_levels();
      return 0;
    end
    if (k == K_SEND || k == K_RECV) begin
      if (k == K_SEND) m_shift = {m_shift[6:0], 1'b0};
      m_bits++;
      if (m_bits < 8) begin
        m_step = 0;
        set_levels();
        return 0;
      end
    end
    case (m_ph)
      PH_START1:  enter_phase(PH_DEVW, m_dev);
      PH_DEVW:    enter_phase(PH_ACKDEVW, 8'h00);
      PH_ACKDEVW: begin
        if (sda) enter_phase(PH_STOPFAIL, 8'h00);
        else enter_phase(PH_REG, m_addr);
      end
      PH_REG:     enter_phase(PH_ACKREG, 8'h00);
      PH_ACKREG: begin
        if (m_rd) enter_phase(PH_STOPMID, 8'h00);
        else enter_phase(PH_DATA, m_data);
      end
      PH_DATA:    enter_phase(PH_ACKDATA, 8'h00);
      PH_ACKDATA: enter_phase(PH_STOPEND, 8'h00);
      PH_STOPMID: enter_phase(PH_START2, 8'h00);
      PH_START2:  enter_phase(PH_DEVR, m_dev + 8'd1);
      PH_DEVR:    enter_phase(PH_ACKDEVR, 8'h00);
      PH_ACKDEVR: begin
        if (sda) enter_phase(PH_STOPFAIL, 8'h00);
        else enter_phase(PH_RECV, 8'h00);
      end
      PH_RECV: begin
        m_rx = m_shift;
        enter_phase(PH_NOACK, 8'h00);
      end
      PH_NOACK:   enter_phase(PH_STOPEND, 8'h00);
      default: begin
        result = (m_ph == PH_STOPEND) ? 1 : 2;
        m_ph = PH_IDLE;
        m_step = 0;
        m_bits = 0;
        return result;
      end
    endcase
    return 0;
  endfunction

  function automatic res_t advance_bus(logic [1:0] op, logic [7:0] a, logic [7:0] d,
                                       logic sda);
    res_t r;
    int lim;
    int code;
    r = '0;
    if (m_ph == PH_IDLE && (op == REQ_WRITE || op == REQ_READ)) begin
      m_rd = (op == REQ_READ);
      m_addr = a;
      m_data = d;
      m_ticks = 0;
      enter_phase(PH_START1, 8'h00);
    end
    r.scl = m_lines[1];
    r.sda = m_lines[0];
    if (m_ph != PH_IDLE) begin
      lim = (m_delay == 16'd0) ? 1 : int'(m_delay);
      if (m_ticks + 1 >= lim) begin
        m_ticks = 0;
        code = close_step(sda);
        if (code != 0) begin
          r.done = 1'b1;
          r.success = (code == 1);
        end
      end else begin
        m_ticks++;
      end
    end
    r.busy = (m_ph != PH_IDLE);
    r.read_byte = m_rx;
    return r;
  endfunction

  task automatic flag(input string what, input logic [7:0] got, input logic [7:0] want);
    bad_count++;
    $display("mismatch on %s at beat %0d: got %0h, want %0h", what, beats_seen, got, want);
  endtask

  task automatic put_tick(input logic [1:0] op, input logic [7:0] a, input logic [7:0] d,
                          input logic s, input logic typed, input res_t want);
    res_t p;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= op;
    reg_addr <= a;
    wr_data <= d;
    sda_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = advance_bus(op, a, d, s);
    tick_out_q.push_back(typed ? want : p);
    items_fed++;
  endtask

  // device side: answers the address acks and returns rx on a read; ACK_NOISE answers every step at random
  task automatic run_bus(input reply_t rep, input logic [7:0] rx);
    logic s;
    while (m_ph != PH_IDLE) begin
      if (rep == ACK_NOISE) begin
        s = rand_bit();
      end else begin
        case (m_ph)
          PH_ACKDEVW: s = (rep == NACK_DEVW);
          PH_ACKDEVR: s = (rep == NACK_DEVR);
          PH_RECV:    s = rx[7 - m_bits];
          default:    s = rand_bit();
        endcase
      end
      put_tick(2'($urandom_range(0, 3)), rand_byte(), rand_byte(), s, 1'b0, '0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tick_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(input logic idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_DEV_ADDR) m_dev = val[7:0];
    else m_delay = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] dev, input logic [15:0] dly);
    logic [7:0] junk;
    junk = rand_byte();
    settle();
    set_cfg(CFG_DEV_ADDR, {junk, dev});
    set_cfg(CFG_DELAY, dly);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tick_out_q.size() == 0) begin
        flag("beat with nothing expected", 8'h00, 8'h00);
      end else begin
        head = tick_out_q.pop_front();
        if (scl_out !== head.scl) flag("scl_out", 8'(scl_out), 8'(head.scl));
        if (sda_out !== head.sda) flag("sda_out", 8'(sda_out), 8'(head.sda));
        if (busy_res !== head.busy) flag("busy_res", 8'(busy_res), 8'(head.busy));
        if (done_res !== head.done) flag("done_res", 8'(done_res), 8'(head.done));
        if (success !== head.success) flag("success", 8'(success), 8'(head.success));
        if (read_byte !== head.read_byte) flag("read_byte", read_byte, head.read_byte);
      end
      beats_seen++;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 4) < 3);
      default: out_stall <= (cycle_count % 3 == 0);
    endcase
  end

  initial begin
    script_row_t row;
    logic [1:0] op;
    logic [7:0] dev;
    logic [15:0] dly;
    reply_t rep;
    int sel;
    int base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.dev != m_dev || row.dly != m_delay) configure(row.dev, row.dly);
      put_tick(row.op, row.addr, row.data, rand_bit(), row.typed, row.want);
      run_bus(row.reply, row.rx);
    end

    base = items_fed;
    while (items_fed - base < 100) begin
      sel = $urandom_range(0, 5);
      if (sel == 0) dev = 8'd0;
      else if (sel == 1) dev = 8'd255;
      else if (sel == 2) dev = 8'd254;
      else dev = rand_byte();
      sel = $urandom_range(0, 9);
      if (sel == 0) dly = 16'd0;
      else if (sel < 6) dly = 16'd1;
      else if (sel < 9) dly = 16'($urandom_range(2, 3));
      else dly = 16'($urandom_range(4, 8));
      configure(dev, dly);
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 6;
      endcase
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 6))
          put_tick(rand_bit() ? TICK_PLAIN : TICK_ODD, rand_byte(), rand_byte(), rand_bit(),
                   1'b0, '0);
        op = rand_bit() ? REQ_WRITE : REQ_READ;
        sel = $urandom_range(0, 19);
        if (sel == 0) rep = NACK_DEVW;
        else if (sel == 1) rep = NACK_DEVR;
        else if (sel == 2) rep = ACK_NOISE;
        else rep = ACK_ALL;
        put_tick(op, rand_byte(), rand_byte(), rand_bit(), 1'b0, '0);
        run_bus(rep, rand_byte());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (bad_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
